// ===== design/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types, codes and helpers shared by the Go-Back-N sender modules.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_SEQ_BITS = 6;
  localparam int SEQ_W        = MAX_SEQ_BITS;
  localparam int OP_W         = 3;
  localparam int KIND_W       = 2;
  localparam int SBITS_W      = 3;
  localparam int TICK_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [SEQ_W-1:0] QUEUE_MAX = {SEQ_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_START  = 3'd0,
    OP_TICK   = 3'd1,
    OP_QREPLY = 3'd2,
    OP_ACK    = 3'd3,
    OP_RNR    = 3'd4,
    OP_RR     = 3'd5
  } op_e_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUERY = 2'd0,
    KIND_NEW   = 2'd1,
    KIND_RETX  = 2'd2
  } kind_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_BITS = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_INTERVAL = 2'd2
  } cfg_idx_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_e_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic emit_query;
    logic emit_retx;
    logic emit_send;
    logic disarm;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic query_pend;
    logic retx_pend;
    logic retx_one;
    logic try_pend;
    logic send_ok;
    logic slot_free;
  } dp_status_t;

  // sequence-number mask; width clamped to 1..MAX_SEQ_BITS
  function automatic logic [SEQ_W-1:0] seq_mask(input logic [SBITS_W-1:0] bits);
    logic [SBITS_W-1:0] b;
    logic [SEQ_W:0]     m;
    b = bits;
    if (b < SBITS_W'(1)) b = SBITS_W'(1);
    if (b > SBITS_W'(MAX_SEQ_BITS)) b = SBITS_W'(MAX_SEQ_BITS);
    m = ((SEQ_W+1)'(1) << b) - (SEQ_W+1)'(1);
    return m[SEQ_W-1:0];
  endfunction

endpackage

// ===== design/gbn_in_if.sv =====
// ----------------------------------------------------------------------------
// gbn_in_if
// Event channel into the sender: op code and number.
// ----------------------------------------------------------------------------
interface gbn_in_if;
  logic                       valid;
  logic                       ready;
  logic [gbn_pkg::OP_W-1:0]   op;
  logic [gbn_pkg::SEQ_W-1:0]  number;

  modport source (output valid, output op, output number, input ready);
  modport sink   (input valid, input op, input number, output ready);
endinterface

// ===== design/gbn_out_if.sv =====
// ----------------------------------------------------------------------------
// gbn_out_if
// Packet channel out of the sender: kind, sequence number, last flag.
// ----------------------------------------------------------------------------
interface gbn_out_if;
  logic                       valid;
  logic                       ready;
  logic [gbn_pkg::KIND_W-1:0] kind;
  logic [gbn_pkg::SEQ_W-1:0]  seq;
  logic                       last;

  modport source (output valid, output kind, output seq, output last, input ready);
  modport sink   (input valid, input kind, input seq, input last, output ready);
endinterface

// ===== design/gbn_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gbn_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gbn_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbn_pkg::CFG_IDX_W-1:0]  index;
  logic [gbn_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/gbn_dp.sv =====
// ----------------------------------------------------------------------------
// gbn_dp
// Datapath: config registers, protocol state, timers, queue window and the
// output register.
// ----------------------------------------------------------------------------
module gbn_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  gbn_pkg::dp_cmd_t          cmd,
  output gbn_pkg::dp_status_t       status,
  input  logic [gbn_pkg::OP_W-1:0]  req_op,
  input  logic [gbn_pkg::SEQ_W-1:0] req_number,
  gbn_out_if.source                 rsp,
  gbn_cfg_if.sink                   cfg
);
  import gbn_pkg::*;

  logic [SBITS_W-1:0] seq_bits;
  logic [TICK_W-1:0]  timeout_ticks;
  logic [TICK_W-1:0]  send_interval_ticks;

  logic [OP_W-1:0]    op_q;
  logic [SEQ_W-1:0]   number_q;

  logic [SEQ_W-1:0]   window_size;
  logic [SEQ_W-1:0]   send_base;
  logic [SEQ_W-1:0]   next_seq;
  logic [SEQ_W-1:0]   queue_head;
  logic [SEQ_W-1:0]   queue_count;
  logic               receiver_ready;
  logic               send_armed;
  logic               timeout_running;
  logic [TICK_W-1:0]  timeout_count;
  logic [TICK_W-1:0]  send_count;

  logic [SEQ_W-1:0]   retx_left;
  logic [SEQ_W-1:0]   retx_ptr;
  logic               query_pend;
  logic               try_pend;

  logic               out_valid;
  logic [KIND_W-1:0]  out_kind;
  logic [SEQ_W-1:0]   out_seq;
  logic               out_last;

  logic [SEQ_W-1:0]   mask;
  logic [TICK_W-1:0]  eff_timeout;
  logic [TICK_W-1:0]  eff_interval;
  logic [SEQ_W-1:0]   seq_gap;
  logic               send_ok;
  logic [SEQ_W-1:0]   ack_k;
  logic               ack_hit;
  logic [SEQ_W-1:0]   ack_count;
  logic               emit_any;

  assign mask         = seq_mask(seq_bits);
  assign eff_timeout  = (timeout_ticks == '0) ? TICK_W'(1) : timeout_ticks;
  assign eff_interval = (send_interval_ticks == '0) ? TICK_W'(1) : send_interval_ticks;

  // modular distance from the base decides whether the window has room
  assign seq_gap = (next_seq - send_base) & mask;
  assign send_ok = receiver_ready && (seq_gap < window_size) && (queue_count != QUEUE_MAX);

  assign ack_k     = (number_q - queue_head) & mask;
  assign ack_hit   = (number_q <= mask) && (ack_k < queue_count);
  assign ack_count = ack_hit ? (queue_count - ack_k) : '0;

  assign emit_any = cmd.emit_query | cmd.emit_retx | cmd.emit_send;

  assign status.query_pend = query_pend;
  assign status.retx_pend  = (retx_left != '0);
  assign status.retx_one   = (retx_left == SEQ_W'(1));
  assign status.try_pend   = try_pend;
  assign status.send_ok    = send_ok;
  assign status.slot_free  = !out_valid || rsp.ready;

  assign cfg.ready  = 1'b1;
  assign rsp.valid  = out_valid;
  assign rsp.kind   = out_kind;
  assign rsp.seq    = out_seq;
  assign rsp.last   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bits            <= SBITS_W'(3);
      timeout_ticks       <= TICK_W'(5000);
      send_interval_ticks <= TICK_W'(1000);
      window_size         <= '0;
      send_base           <= '0;
      next_seq            <= '0;
      queue_head          <= '0;
      queue_count         <= '0;
      receiver_ready      <= 1'b1;
      send_armed          <= 1'b0;
      timeout_running     <= 1'b0;
      timeout_count       <= '0;
      send_count          <= '0;
      retx_left           <= '0;
      retx_ptr            <= '0;
      query_pend          <= 1'b0;
      try_pend            <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_SEQ_BITS: seq_bits            <= cfg.data[SBITS_W-1:0];
          CFG_TIMEOUT:  timeout_ticks       <= cfg.data[TICK_W-1:0];
          CFG_INTERVAL: send_interval_ticks <= cfg.data[TICK_W-1:0];
          default: ;
        endcase
      end

      if (cmd.eval) begin
        case (op_q)
          OP_START: begin
            window_size     <= '0;
            send_base       <= '0;
            next_seq        <= '0;
            queue_head      <= '0;
            queue_count     <= '0;
            receiver_ready  <= 1'b1;
            send_armed      <= 1'b0;
            timeout_running <= 1'b0;
            timeout_count   <= '0;
            send_count      <= '0;
            query_pend      <= 1'b1;
          end
          OP_TICK: begin
            if (timeout_running) begin
              if (timeout_count > TICK_W'(1)) begin
                timeout_count <= timeout_count - TICK_W'(1);
              end else begin
                timeout_count <= eff_timeout;
                retx_left     <= queue_count;
                retx_ptr      <= queue_head;
              end
            end
            if (send_armed) begin
              if (send_count > TICK_W'(1)) begin
                send_count <= send_count - TICK_W'(1);
              end else begin
                try_pend <= 1'b1;
              end
            end
          end
          OP_QREPLY: begin
            window_size <= number_q;
            try_pend    <= 1'b1;
          end
          OP_ACK: begin
            send_base <= number_q;
            if (ack_hit) queue_head <= number_q;
            queue_count <= ack_count;
            if (ack_count != '0) begin
              timeout_running <= 1'b1;
              timeout_count   <= eff_timeout;
            end else begin
              timeout_running <= 1'b0;
              timeout_count   <= '0;
            end
          end
          OP_RNR: receiver_ready <= 1'b0;
          OP_RR: begin
            receiver_ready <= 1'b1;
            try_pend       <= 1'b1;
          end
          default: ;
        endcase
      end

      if (cmd.emit_query) query_pend <= 1'b0;

      if (cmd.emit_retx) begin
        retx_left <= retx_left - SEQ_W'(1);
        retx_ptr  <= retx_ptr + SEQ_W'(1);
      end

      if (cmd.emit_send) begin
        if (queue_count == '0) queue_head <= next_seq & mask;
        queue_count <= queue_count + SEQ_W'(1);
        if (!timeout_running) begin
          timeout_running <= 1'b1;
          timeout_count   <= eff_timeout;
        end
        next_seq   <= (next_seq + SEQ_W'(1)) & mask;
        send_armed <= 1'b1;
        send_count <= eff_interval;
        try_pend   <= 1'b0;
      end

      if (cmd.disarm) begin
        send_armed <= 1'b0;
        try_pend   <= 1'b0;
      end

      if (emit_any) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= req_op;
      number_q <= req_number;
    end
    if (emit_any) begin
      out_last <= cmd.last;
      if (cmd.emit_query) begin
        out_kind <= KIND_QUERY;
        out_seq  <= '0;
      end else if (cmd.emit_retx) begin
        out_kind <= KIND_RETX;
        out_seq  <= retx_ptr & mask;
      end else begin
        out_kind <= KIND_NEW;
        out_seq  <= next_seq & mask;
      end
    end
  end

endmodule

// ===== design/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// Controller: takes one event, has the datapath evaluate it, then sequences
// the query, retransmit burst and new-data send into the output register.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gbn_pkg::dp_status_t status,
  output gbn_pkg::dp_cmd_t    cmd
);
  import gbn_pkg::*;

  state_e_t state;
  state_e_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!status.query_pend && !status.retx_pend && !status.try_pend) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EVAL: cmd.eval = 1'b1;
      ST_EMIT: begin
        if (status.query_pend) begin
          cmd.emit_query = status.slot_free;
          cmd.last       = 1'b1;
        end else if (status.retx_pend) begin
          cmd.emit_retx = status.slot_free;
          // the burst ends the transaction unless a new send follows it
          cmd.last      = status.retx_one && !(status.try_pend && status.send_ok);
        end else if (status.try_pend) begin
          if (status.send_ok) begin
            cmd.emit_send = status.slot_free;
            cmd.last      = 1'b1;
          end else begin
            cmd.disarm = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/go_back_n_sender.sv =====
// Order: an accepted event passes IDLE, EVAL and EMIT; in EMIT its first packet enters the output register.
// Flow: the controller takes a new event only in IDLE, once every packet of the
//   last one has been emitted; a timeout burst emits one sequence number per
//   cycle while the output register is free (not held by rsp.ready).
// Reset: rst (synchronous) restores config defaults 3/5000/1000 and clears
//   all protocol state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-Back-N ARQ sender: query handshake, paced new sends, timeout resend.
// ----------------------------------------------------------------------------
module go_back_n_sender (
  input  logic      clk,
  input  logic      rst,
  gbn_in_if.sink    req,
  gbn_out_if.source rsp,
  gbn_cfg_if.sink   cfg
);
  import gbn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign req.ready = in_ready;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .req_op     (req.op),
    .req_number (req.number),
    .rsp        (rsp),
    .cfg        (cfg)
  );

endmodule
